// ===== hdl/csl_pkg.sv =====
`timescale 1ns / 1ps

package csl_pkg;

   // keyword table geometry
   localparam int KW_ROWS  = 32;
   localparam int KW_COLS  = 16;
   localparam int KW_IDX_W = $clog2(KW_COLS);

   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_EQ   = 3'd1,
      MODE_REL  = 3'd2,
      MODE_NUM  = 3'd3,
      MODE_ID   = 3'd4
   } scan_mode_type;

   typedef enum logic [3:0] {
      TOK_SEMI    = 4'd0,
      TOK_ARITH   = 4'd1,
      TOK_OPEN    = 4'd2,
      TOK_CLOSE   = 4'd3,
      TOK_SPECIAL = 4'd4,
      TOK_ASSIGN  = 4'd5,
      TOK_RELOP   = 4'd6,
      TOK_FLOAT   = 4'd7,
      TOK_NUMBER  = 4'd8,
      TOK_KEYWORD = 4'd9,
      TOK_IDENT   = 4'd10,
      TOK_UNKNOWN = 4'd11
   } tok_class_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      tok_class_type token_class;
      logic [15:0]   serial_number;
      logic [15:0]   line_number;
      logic [23:0]   start_offset;
      logic [4:0]    token_length;
      logic [4:0]    keyword_index;
      logic          last_of_run;
   } rsp_type;

   // one token candidate inside the scanner
   typedef struct packed {
      logic    valid;
      rsp_type tok;
   } tok_slot_type;

   typedef logic [KW_COLS*8-1:0]          kw_text_type;
   typedef logic [KW_COLS-1:0][7:0]       kw_row_type;
   typedef kw_row_type [KW_ROWS-1:0]      kw_table_type;

   // keyword spellings, right-justified as string literals
   localparam kw_text_type KW_TEXT [KW_ROWS] = '{
      0: "int",     1: "float",    2: "double",   3: "char",
      4: "void",    5: "main",     6: "if",       7: "else",
      8: "for",     9: "while",    10: "do",      11: "printf",
      12: "scanf",  13: "stdio.h", 14: "string.h", 15: "stdlib.h",
      16: "conio.h",
      default: '0
   };

   // turn the literals into a table indexed by character position
   function automatic kw_table_type kw_build();
      kw_table_type t;
      int           len;
      t = '0;
      for (int k = 0; k < KW_ROWS; k++) begin
         len = 0;
         for (int b = 0; b < KW_COLS; b++) begin
            if (KW_TEXT[k][b*8 +: 8] != 8'h00) len++;
         end
         for (int p = 0; p < KW_COLS; p++) begin
            if (p < len) t[k][p] = KW_TEXT[k][(len-1-p)*8 +: 8];
         end
      end
      return t;
   endfunction

   localparam kw_table_type KW_TABLE = kw_build();

   function automatic int kw_length(int k);
      int len;
      len = 0;
      for (int p = 0; p < KW_COLS; p++) begin
         if (KW_TABLE[k][p] != 8'h00 && len == p) len++;
      end
      return len;
   endfunction

endpackage

// ===== hdl/c_subset_lexer_top.sv =====
`timescale 1ns / 1ps

// channel   ports            payload              direction
// request   req_valid/ready  csl_pkg::req_type    in  (source byte, end flag)
// response  rsp_valid/ready  csl_pkg::rsp_type    out (one token each)
//
// one source byte is taken per cycle while req_ready is high; the decode,
// keyword compare and token build sit between the scanner state and a
// four-entry response queue. a byte yields zero, one or two tokens; the queue
// drains one token per cycle, so the byte rate follows the token rate once
// two-token bytes pile up. req_ready is high while the queue has room for two
// tokens. reset is synchronous and active high; it clears scanner state and
// queue pointers; a stalled response blocks intake once three tokens wait

module c_subset_lexer_top #(
   parameter int MAX_LEXEME    = 24,
   parameter int KEYWORD_COUNT = 17,
   parameter int KEYWORD_CHARS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  csl_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output csl_pkg::rsp_type rsp_payload
);

   localparam int LEX_W      = $clog2(MAX_LEXEME + 1);
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   // scanner state
   csl_pkg::scan_mode_type   mode_ff, mode_in;
   logic [LEX_W-1:0]         lex_ff, lex_in;
   logic                     saw_ff, saw_in;
   logic [KEYWORD_COUNT-1:0] alive_ff, alive_in;
   logic [15:0]              line_ff, line_in;
   logic [15:0]              tok_ff, tok_in;
   logic [23:0]              offset_ff, offset_in;
   logic [23:0]              start_ff, start_in;

   // response queue
   csl_pkg::rsp_type         result_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]         wptr_ff, wptr_in;
   logic [PTR_W-1:0]         rptr_ff, rptr_in;
   logic [CNT_W-1:0]         count_ff, count_in;

   logic                     req_accept;
   logic                     rsp_accept;
   logic [1:0]               n_res;
   csl_pkg::rsp_type         res_a, res_b;

   csl_pkg::tok_slot_type    first_tok, second_tok, pending_done, closing;
   logic [KEYWORD_COUNT-1:0] grow_id, grow_new;
   logic [LEX_W-1:0]         lex_sat;
   logic                     taken;
   logic [7:0]               ch;
   logic                     is_dig, is_alp, is_dot, is_idch;

   // character of keyword k at position pos, zero past its end
   function automatic logic [7:0] kw_char(int k, logic [LEX_W-1:0] pos);
      if (int'(pos) < KEYWORD_CHARS)
         return csl_pkg::KW_TABLE[k][pos[csl_pkg::KW_IDX_W-1:0]];
      return 8'h00;
   endfunction

   function automatic int kw_eff_len(int k);
      int len;
      len = csl_pkg::kw_length(k);
      return (len < KEYWORD_CHARS) ? len : KEYWORD_CHARS;
   endfunction

   // drop keywords whose character at pos differs from c
   function automatic logic [KEYWORD_COUNT-1:0] grow_alive(
      logic [LEX_W-1:0] pos, logic [7:0] c, logic [KEYWORD_COUNT-1:0] alive);
      logic [KEYWORD_COUNT-1:0] a;
      a = alive;
      for (int k = 0; k < KEYWORD_COUNT; k++) begin
         if (kw_char(k, pos) != c) a[k] = 1'b0;
      end
      return a;
   endfunction

   function automatic csl_pkg::tok_slot_type single_tok(
      csl_pkg::tok_class_type cls, logic [23:0] start);
      csl_pkg::tok_slot_type s;
      s = '0;
      s.valid = 1'b1;
      s.tok.token_class  = cls;
      s.tok.start_offset = start;
      s.tok.token_length = 5'd1;
      return s;
   endfunction

   // token left behind by a pending scan mode
   function automatic csl_pkg::tok_slot_type finish_tok(
      csl_pkg::scan_mode_type m, logic saw, logic [LEX_W-1:0] lex,
      logic [KEYWORD_COUNT-1:0] alive, logic [23:0] start);
      csl_pkg::tok_slot_type s;
      logic                  found;
      s = '0;
      found = 1'b0;
      unique case (m)
         csl_pkg::MODE_EQ:  s = single_tok(csl_pkg::TOK_ASSIGN, start);
         csl_pkg::MODE_REL: s = single_tok(csl_pkg::TOK_RELOP, start);
         csl_pkg::MODE_NUM: begin
            s.valid = 1'b1;
            s.tok.token_class  = saw ? csl_pkg::TOK_FLOAT : csl_pkg::TOK_NUMBER;
            s.tok.start_offset = start;
            s.tok.token_length = 5'(lex);
         end
         csl_pkg::MODE_ID: begin
            s.valid = 1'b1;
            s.tok.token_class  = csl_pkg::TOK_IDENT;
            s.tok.start_offset = start;
            s.tok.token_length = 5'(lex);
            // lowest live keyword of matching length wins
            for (int k = 0; k < KEYWORD_COUNT; k++) begin
               if (!found && alive[k] && int'(lex) == kw_eff_len(k)) begin
                  found = 1'b1;
                  s.tok.token_class   = csl_pkg::TOK_KEYWORD;
                  s.tok.keyword_index = 5'(k);
               end
            end
         end
         default: s = '0;
      endcase
      return s;
   endfunction

   assign req_accept = req_valid && req_ready;
   assign rsp_accept = rsp_valid && rsp_ready;
   assign req_ready  = count_ff <= CNT_W'(FIFO_DEPTH - 2);
   assign rsp_valid  = count_ff != '0;
   assign rsp_payload = result_ff[rptr_ff];

   // character classes
   assign ch      = req_payload.in_byte;
   assign is_dig  = ch >= "0" && ch <= "9";
   assign is_alp  = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
   assign is_dot  = ch == ".";
   assign is_idch = is_alp || is_dig || is_dot || ch == "_";

   assign lex_sat      = (lex_ff < LEX_W'(MAX_LEXEME)) ? lex_ff + LEX_W'(1) : lex_ff;
   assign grow_id      = grow_alive(lex_ff, ch, alive_ff);
   assign grow_new     = grow_alive('0, ch, '1);
   assign pending_done = finish_tok(mode_ff, saw_ff, lex_ff, alive_ff, start_ff);

   always_comb begin
      mode_in    = mode_ff;
      lex_in     = lex_ff;
      saw_in     = saw_ff;
      alive_in   = alive_ff;
      line_in    = line_ff;
      start_in   = start_ff;
      offset_in  = offset_ff + 24'd1;
      first_tok  = '0;
      second_tok = '0;
      closing    = '0;
      taken      = 1'b0;

      // continue or close the pending token
      unique case (mode_ff)
         csl_pkg::MODE_EQ, csl_pkg::MODE_REL: begin
            mode_in = csl_pkg::MODE_IDLE;
            if (ch == "=") begin
               first_tok = single_tok(csl_pkg::TOK_RELOP, start_ff);
               first_tok.tok.token_length = 5'd2;
               taken = 1'b1;
            end else begin
               first_tok = pending_done;
            end
         end
         csl_pkg::MODE_NUM: begin
            if (is_dig || is_dot) begin
               saw_in = saw_ff || is_dot;
               lex_in = lex_sat;
               taken  = 1'b1;
            end else begin
               first_tok = pending_done;
               mode_in   = csl_pkg::MODE_IDLE;
            end
         end
         csl_pkg::MODE_ID: begin
            if (is_idch) begin
               alive_in = grow_id;
               lex_in   = lex_sat;
               taken    = 1'b1;
            end else begin
               first_tok = pending_done;
               mode_in   = csl_pkg::MODE_IDLE;
            end
         end
         default: mode_in = csl_pkg::MODE_IDLE;
      endcase

      // fresh character
      if (!taken) begin
         priority if (ch == " " || ch == "\t") begin
            mode_in = mode_in;
         end else if (ch == "\n") begin
            line_in = line_ff + 16'd1;
         end else if (ch == ";") begin
            second_tok = single_tok(csl_pkg::TOK_SEMI, offset_ff);
         end else if (ch == "+" || ch == "-" || ch == "*" || ch == "/") begin
            second_tok = single_tok(csl_pkg::TOK_ARITH, offset_ff);
         end else if (ch == "{" || ch == "[" || ch == "(") begin
            second_tok = single_tok(csl_pkg::TOK_OPEN, offset_ff);
         end else if (ch == "}" || ch == "]" || ch == ")") begin
            second_tok = single_tok(csl_pkg::TOK_CLOSE, offset_ff);
         end else if (ch == "&" || ch == ":" || ch == ",") begin
            second_tok = single_tok(csl_pkg::TOK_SPECIAL, offset_ff);
         end else if (ch == "=") begin
            mode_in  = csl_pkg::MODE_EQ;
            start_in = offset_ff;
         end else if (ch == "<" || ch == ">" || ch == "!") begin
            mode_in  = csl_pkg::MODE_REL;
            start_in = offset_ff;
         end else if (is_dig) begin
            mode_in  = csl_pkg::MODE_NUM;
            start_in = offset_ff;
            lex_in   = LEX_W'(1);
            saw_in   = 1'b0;
         end else if (is_alp) begin
            mode_in  = csl_pkg::MODE_ID;
            start_in = offset_ff;
            lex_in   = LEX_W'(1);
            alive_in = grow_new;
         end else begin
            second_tok = single_tok(csl_pkg::TOK_UNKNOWN, offset_ff);
         end
      end

      // end of source: flush whatever this byte left pending, then restart
      if (req_payload.end_of_input) begin
         closing = finish_tok(mode_in, saw_in, lex_in, alive_in, start_in);
         if (closing.valid) second_tok = closing;
         mode_in   = csl_pkg::MODE_IDLE;
         lex_in    = '0;
         saw_in    = 1'b0;
         alive_in  = '1;
         line_in   = 16'd1;
         offset_in = '0;
         start_in  = '0;
      end
   end

   // pack the tokens of this byte into order and number them
   always_comb begin
      if (first_tok.valid) begin
         res_a = first_tok.tok;
         res_b = second_tok.tok;
         n_res = second_tok.valid ? 2'd2 : 2'd1;
      end else begin
         res_a = second_tok.tok;
         res_b = second_tok.tok;
         n_res = second_tok.valid ? 2'd1 : 2'd0;
      end
      res_a.serial_number = tok_ff;
      res_b.serial_number = tok_ff + 16'd1;
      res_a.line_number   = line_ff;
      res_b.line_number   = line_ff;
      res_a.last_of_run   = n_res == 2'd1;
      res_b.last_of_run   = 1'b1;
      tok_in = req_payload.end_of_input ? 16'd1 : tok_ff + 16'(n_res);
   end

   // queue pointers
   always_comb begin
      wptr_in  = req_accept ? wptr_ff + PTR_W'(n_res) : wptr_ff;
      rptr_in  = rsp_accept ? rptr_ff + PTR_W'(1) : rptr_ff;
      count_in = count_ff + CNT_W'(req_accept ? n_res : 2'd0) - CNT_W'(rsp_accept);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= csl_pkg::MODE_IDLE;
         lex_ff    <= '0;
         saw_ff    <= 1'b0;
         alive_ff  <= '1;
         line_ff   <= 16'd1;
         tok_ff    <= 16'd1;
         offset_ff <= '0;
         start_ff  <= '0;
         wptr_ff   <= '0;
         rptr_ff   <= '0;
         count_ff  <= '0;
      end else begin
         if (req_accept) begin
            mode_ff   <= mode_in;
            lex_ff    <= lex_in;
            saw_ff    <= saw_in;
            alive_ff  <= alive_in;
            line_ff   <= line_in;
            tok_ff    <= tok_in;
            offset_ff <= offset_in;
            start_ff  <= start_in;
         end
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept && n_res != 2'd0) result_ff[wptr_ff] <= res_a;
      if (req_accept && n_res == 2'd2) result_ff[wptr_ff + PTR_W'(1)] <= res_b;
   end

   // queue never overfills
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("response queue overfilled");

   // a token that is not last of its byte always has its partner queued
   a_pair_queued: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last_of_run |-> count_ff >= CNT_W'(2))
      else $error("first of a token pair queued alone");

   // numbers and identifiers always hold at least one character
   a_lex_nonzero: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == csl_pkg::MODE_NUM || mode_ff == csl_pkg::MODE_ID) |-> lex_ff != '0)
      else $error("empty lexeme in a scan mode");

   // end of input restarts the source
   a_flush_restart: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_payload.end_of_input |=>
         mode_ff == csl_pkg::MODE_IDLE && line_ff == 16'd1 && tok_ff == 16'd1
         && offset_ff == '0)
      else $error("scanner not restarted after end of input");

endmodule
